@@ sv/mte_pkg.sv @@
// mte_pkg: shared types and constants of the midi track event encoder
// no dependencies; used by the interfaces and every module of the block
package mte_pkg;

    localparam int unsigned VLQ_BYTES      = 4;   // 28-bit delta in 7-bit groups
    localparam int unsigned DATA_FIELDS    = 4;   // data byte fields in one event
    localparam int unsigned CHANNEL_DATA   = 2;   // data bytes of a channel message
    localparam int unsigned META_HDR_BYTES = 3;   // 0xff, type, length
    localparam int unsigned CNT_W          = 4;   // holds any byte count up to 11

    localparam logic [7:0] VLQ_CONT  = 8'h80;
    localparam logic [7:0] VLQ_MASK  = 8'h7F;
    localparam logic [7:0] META_MARK = 8'hFF;

    typedef enum logic
    {
        CMD_CHANNEL = 1'b0,
        CMD_META    = 1'b1
    } command_t;

    typedef struct packed
    {
        command_t    command;
        logic [27:0] delta_time;
        logic [7:0]  event_code;
        logic [2:0]  data_count;
        logic [7:0]  data_byte_0;
        logic [7:0]  data_byte_1;
        logic [7:0]  data_byte_2;
        logic [7:0]  data_byte_3;
    } event_t;

    typedef struct packed
    {
        logic [7:0] track_byte;
        logic       last_byte;
    } track_t;

endpackage

@@ sv/mte_event_if.sv @@
// mte_event_if: valid/ready channel carrying one event item
// depends on mte_pkg
interface mte_event_if;
    logic            valid;
    logic            ready;
    mte_pkg::event_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ sv/mte_track_if.sv @@
// mte_track_if: valid/ready channel carrying one encoded track byte
// depends on mte_pkg
interface mte_track_if;
    logic            valid;
    logic            ready;
    mte_pkg::track_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ sv/mte_encoder.sv @@
// mte_encoder: builds the byte frame of one event and keeps running status
// depends on mte_pkg
module mte_encoder #(
    parameter int unsigned FRAME_BYTES = 11,
    parameter int unsigned META_LIM    = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mte_pkg::event_t             item,
    input  logic                        load,
    output logic [7:0]                  frame [FRAME_BYTES],
    output logic [mte_pkg::CNT_W-1:0]   last_idx
);

    logic [7:0]                running_status_reg;
    logic [7:0]                running_status_next;
    logic [7:0]                vlq     [mte_pkg::VLQ_BYTES];
    logic [7:0]                hdr     [mte_pkg::META_HDR_BYTES];
    logic [7:0]                data    [mte_pkg::DATA_FIELDS];
    logic [mte_pkg::CNT_W-1:0] n_vlq;
    logic [mte_pkg::CNT_W-1:0] n_hdr;
    logic [mte_pkg::CNT_W-1:0] n_data;
    logic [mte_pkg::CNT_W-1:0] cnt;
    logic [mte_pkg::CNT_W-1:0] len;
    logic                      status_new;

    always_comb
    begin
        vlq[0] = mte_pkg::VLQ_CONT | {1'b0, item.delta_time[27:21]};
        vlq[1] = mte_pkg::VLQ_CONT | {1'b0, item.delta_time[20:14]};
        vlq[2] = mte_pkg::VLQ_CONT | {1'b0, item.delta_time[13:7]};
        vlq[3] = {1'b0, item.delta_time[6:0]} & mte_pkg::VLQ_MASK;

        if (item.delta_time[27:21] != '0)
            n_vlq = mte_pkg::CNT_W'(4);
        else if (item.delta_time[20:14] != '0)
            n_vlq = mte_pkg::CNT_W'(3);
        else if (item.delta_time[13:7] != '0)
            n_vlq = mte_pkg::CNT_W'(2);
        else
            n_vlq = mte_pkg::CNT_W'(1);

        data[0] = item.data_byte_0;
        data[1] = item.data_byte_1;
        data[2] = item.data_byte_2;
        data[3] = item.data_byte_3;

        cnt        = {1'b0, item.data_count};
        status_new = (item.event_code != running_status_reg);

        if (item.command == mte_pkg::CMD_CHANNEL)
        begin
            // channel message: status only when it changes, at most two data bytes
            hdr[0] = item.event_code;
            hdr[1] = item.event_code;
            hdr[2] = item.event_code;
            n_hdr  = status_new ? mte_pkg::CNT_W'(1) : '0;
            n_data = (cnt > mte_pkg::CNT_W'(mte_pkg::CHANNEL_DATA))
                   ? mte_pkg::CNT_W'(mte_pkg::CHANNEL_DATA) : cnt;
        end
        else
        begin
            n_data = (cnt > mte_pkg::CNT_W'(META_LIM)) ? mte_pkg::CNT_W'(META_LIM) : cnt;
            hdr[0] = mte_pkg::META_MARK;
            hdr[1] = item.event_code;
            hdr[2] = 8'(n_data);
            n_hdr  = mte_pkg::CNT_W'(mte_pkg::META_HDR_BYTES);
        end

        len      = n_vlq + n_hdr + n_data;
        last_idx = len - mte_pkg::CNT_W'(1);
    end

    // each slot picks its byte from the delta, header or data section
    always_comb
    begin
        logic [mte_pkg::CNT_W-1:0] k;
        logic [mte_pkg::CNT_W-1:0] vi;
        logic [mte_pkg::CNT_W-1:0] hi;
        logic [mte_pkg::CNT_W-1:0] di;
        for (int s = 0; s < FRAME_BYTES; s++)
        begin
            k  = mte_pkg::CNT_W'(s);
            vi = k + mte_pkg::CNT_W'(mte_pkg::VLQ_BYTES) - n_vlq;
            hi = k - n_vlq;
            di = k - n_vlq - n_hdr;
            if (k < n_vlq)
                frame[s] = vlq[vi[1:0]];
            else if (k < n_vlq + n_hdr)
                frame[s] = hdr[(hi[1:0] == 2'd3) ? 2'd2 : hi[1:0]];
            else
                frame[s] = data[di[1:0]];
        end
    end

    always_comb
    begin
        running_status_next = running_status_reg;
        if (load && item.command == mte_pkg::CMD_CHANNEL && status_new)
            running_status_next = item.event_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            running_status_reg <= '0;
        else
            running_status_reg <= running_status_next;
    end

endmodule

@@ sv/mte_serializer.sv @@
// mte_serializer: holds one encoded frame and sends it out a byte per transaction
// depends on mte_pkg and mte_track_if
module mte_serializer #(
    parameter int unsigned FRAME_BYTES = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                frame [FRAME_BYTES],
    input  logic [mte_pkg::CNT_W-1:0] last_idx,
    output logic                      can_load,
    input  logic                      load,
    mte_track_if.source               track
);

    localparam int unsigned IDX_W = $clog2(FRAME_BYTES);

    logic [7:0]       frame_reg [FRAME_BYTES];
    logic [IDX_W-1:0] last_idx_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             busy_reg;
    logic             fire;
    logic             done;

    assign fire     = busy_reg && track.ready;
    assign done     = fire && (idx_reg == last_idx_reg);
    assign can_load = !busy_reg || done;

    assign track.valid              = busy_reg;
    assign track.payload.track_byte = frame_reg[idx_reg];
    assign track.payload.last_byte  = (idx_reg == last_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg    <= frame;
            last_idx_reg <= last_idx[IDX_W-1:0];
        end
    end

endmodule

@@ sv/midi_track_event_encoder.sv @@
// midi_track_event_encoder: one event item in, its track bytes out one per transaction
// an accepted event is held in the input register and encoded combinationally; its first
// byte shows when the serializer loads the frame; one byte per cycle while track.ready;
// an event is 1 to 7 + min(MAX_PAYLOAD_BYTES, 4) bytes, about four for a typical note event
// the byte serializer sets the rate; the next event waits in the input register meanwhile
// reset (rst_n, async low) clears running status to zero and empties both stages
module midi_track_event_encoder #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    mte_event_if.sink   events,
    mte_track_if.source track
);

    // meta payload is capped by the parameter and by the number of data fields
    localparam int unsigned META_LIM = (MAX_PAYLOAD_BYTES < mte_pkg::DATA_FIELDS)
                                     ? MAX_PAYLOAD_BYTES : mte_pkg::DATA_FIELDS;
    // longest frame: full delta, meta header, full payload
    localparam int unsigned FRAME_BYTES = mte_pkg::VLQ_BYTES + mte_pkg::META_HDR_BYTES
                                        + META_LIM;

    // input register: holds the next event while the serializer drains the current one
    logic                      in_valid_reg;
    mte_pkg::event_t           in_item_reg;

    logic [7:0]                frame [FRAME_BYTES];
    logic [mte_pkg::CNT_W-1:0] last_idx;
    logic                      can_load;
    logic                      load;
    logic                      in_fire;

    // a held event moves on as soon as the serializer frees up, same cycle as the last byte
    assign load          = in_valid_reg && can_load;
    assign events.ready  = !in_valid_reg || load;
    assign in_fire       = events.valid && events.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_fire)
            in_valid_reg <= 1'b1;
        else if (load)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_item_reg <= events.payload;
    end

    // encoder: delta vlq, header with running status, clamped data, in one pass
    mte_encoder #(
        .FRAME_BYTES (FRAME_BYTES),
        .META_LIM    (META_LIM)
    ) u_encoder (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (in_item_reg),
        .load     (load),
        .frame    (frame),
        .last_idx (last_idx)
    );

    // serializer: frame register and byte index, one transaction per cycle while track.ready
    mte_serializer #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame),
        .last_idx (last_idx),
        .can_load (can_load),
        .load     (load),
        .track    (track)
    );

endmodule
